### hw/rtl/apucs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package apucs_pkg;
  localparam int NREGS = 23;
  localparam logic [4:0] R_NR10 = 5'd0;
  localparam logic [4:0] R_NR11 = 5'd1;
  localparam logic [4:0] R_NR12 = 5'd2;
  localparam logic [4:0] R_NR13 = 5'd3;
  localparam logic [4:0] R_NR14 = 5'd4;
  localparam logic [4:0] R_NR21 = 5'd6;
  localparam logic [4:0] R_NR22 = 5'd7;
  localparam logic [4:0] R_NR24 = 5'd9;
  localparam logic [4:0] R_NR30 = 5'd10;
  localparam logic [4:0] R_NR31 = 5'd11;
  localparam logic [4:0] R_NR34 = 5'd14;
  localparam logic [4:0] R_NR41 = 5'd16;
  localparam logic [4:0] R_NR42 = 5'd17;
  localparam logic [4:0] R_NR44 = 5'd19;
  localparam logic [4:0] R_NR52 = 5'd22;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  function automatic logic [7:0] clear_val(input logic [4:0] a);
    logic [7:0] v;
    v = 8'h00;
    unique case (a)
      5'd0: v = 8'h80;
      5'd1, 5'd6: v = 8'h3f;
      5'd3, 5'd5, 5'd8, 5'd11, 5'd13, 5'd15, 5'd16: v = 8'hff;
      5'd4, 5'd9, 5'd14, 5'd19: v = 8'hbf;
      5'd10: v = 8'h7f;
      5'd12: v = 8'h9f;
      default: v = 8'h00;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

### hw/rtl/apu_channel_control_sequencer.sv
// Each accepted item's result is registered in the output register, or in the
// skid stage while the output stalls. One item per cycle while the skid stage is empty;
// the one-entry skid stage keeps the input ready while one result waits.
// Reset (rst_n low, synchronous): state cleared except the result data registers,
// register file zero, cgb_mode zero, no result pending.
`timescale 1ns / 1ps
`default_nettype none
module apu_channel_control_sequencer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [4:0]  in_reg_index,
  input  wire logic [7:0]  in_write_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_channel_on,
  output logic [3:0]       out_square1_volume,
  output logic [3:0]       out_square2_volume,
  output logic [3:0]       out_noise_volume,
  output logic [10:0]      out_swept_frequency
);
  typedef struct packed {
    logic [3:0]  on;
    logic [3:0]  v0;
    logic [3:0]  v1;
    logic [3:0]  v3;
    logic [10:0] f;
  } res_t;

  logic        cgb_r;
  logic [7:0]  rf_r [apucs_pkg::NREGS];
  logic [8:0]  len_r [4];
  logic [3:0]  vol_r [4];
  logic [2:0]  etm_r [4];
  logic [7:0]  st_r;
  logic [2:0]  fs_r;
  logic        swe_r;
  logic [3:0]  swt_r;
  logic [10:0] sws_r;
  logic        neg_r;

  logic [7:0]  rf_nxt [apucs_pkg::NREGS];
  logic [8:0]  len_nxt [4];
  logic [3:0]  vol_nxt [4];
  logic [2:0]  etm_nxt [4];
  logic [7:0]  st_nxt;
  logic [2:0]  fs_nxt;
  logic        swe_nxt;
  logic [3:0]  swt_nxt;
  logic [10:0] sws_nxt;
  logic        neg_nxt;

  res_t  out_r, skid_r;
  logic  out_vld_r, skid_vld_r;
  logic  take;

  assign in_ready = !skid_vld_r;
  assign take = in_valid && in_ready;

  function automatic logic [4:0] env_idx(input int ch);
    return 5'(ch * 5 + 2);
  endfunction
  function automatic logic [4:0] ctl_idx(input int ch);
    return 5'(ch * 5 + 4);
  endfunction

  always_comb begin
    logic [7:0]  cnt;
    logic [11:0] fr;
    logic [11:0] fr2;
    logic [10:0] d;
    logic [4:0]  a;
    logic [7:0]  v;
    logic [7:0]  envr;
    logic        gated;
    logic        killed;
    logic        lenclk;
    logic [2:0]  sp;
    rf_nxt  = rf_r;
    len_nxt = len_r;
    vol_nxt = vol_r;
    etm_nxt = etm_r;
    st_nxt  = st_r;
    fs_nxt  = fs_r;
    swe_nxt = swe_r;
    swt_nxt = swt_r;
    sws_nxt = sws_r;
    neg_nxt = neg_r;
    a = in_reg_index;
    v = in_write_value;
    cnt = rf_r[apucs_pkg::R_NR10];
    sp = cnt[6:4];
    fr = '0;
    fr2 = '0;
    d = '0;
    envr = '0;
    killed = 1'b0;
    lenclk = 1'b0;
    gated = 1'b0;
    if (in_cmd == apucs_pkg::CMD_TICK) begin
      for (int ch = 0; ch < 4; ch++) begin
        lenclk = 1'b0;
        if (!fs_r[0] && len_r[ch] != 9'd0 && rf_r[ctl_idx(ch)][6]) begin
          len_nxt[ch] = len_r[ch] - 9'd1;
          lenclk = (len_r[ch] == 9'd1);
        end
        if (lenclk) begin
          st_nxt[ch] = 1'b0;
          if (ch != 2) vol_nxt[ch] = 4'd0;
        end else if (ch != 2 && st_r[ch] && fs_r == 3'd7 && etm_r[ch] != 3'd0) begin
          envr = rf_r[env_idx(ch)];
          etm_nxt[ch] = etm_r[ch] - 3'd1;
          if (etm_r[ch] == 3'd1) begin
            etm_nxt[ch] = envr[2:0];
            if (envr[3]) begin
              if (vol_r[ch] != 4'd15) vol_nxt[ch] = vol_r[ch] + 4'd1;
            end else if (vol_r[ch] != 4'd0) begin
              vol_nxt[ch] = vol_r[ch] - 4'd1;
            end
          end
        end
      end
      if (fs_r[1:0] == 2'd2 && swe_r) begin
        swt_nxt = swt_r - 4'd1;
        if (swt_r == 4'd1) begin
          swt_nxt = (sp == 3'd0) ? 4'd8 : {1'b0, sp};
          if (sp != 3'd0) begin
            d = sws_r >> cnt[2:0];
            fr = cnt[3] ? ({1'b0, sws_r} - {1'b0, d}) : ({1'b0, sws_r} + {1'b0, d});
            if (cnt[3]) neg_nxt = 1'b1;
            if (fr > 12'd2047) begin
              len_nxt[0] = '0; st_nxt[0] = 1'b0; vol_nxt[0] = '0; swe_nxt = 1'b0;
            end else if (cnt[2:0] != 3'd0) begin
              sws_nxt = fr[10:0];
              rf_nxt[apucs_pkg::R_NR13] = fr[7:0];
              rf_nxt[apucs_pkg::R_NR14] = {rf_r[apucs_pkg::R_NR14][7:3], fr[10:8]};
              d = fr[10:0] >> cnt[2:0];
              fr2 = cnt[3] ? ({1'b0, fr[10:0]} - {1'b0, d})
                           : ({1'b0, fr[10:0]} + {1'b0, d});
              if (fr2 > 12'd2047) begin
                len_nxt[0] = '0; st_nxt[0] = 1'b0; vol_nxt[0] = '0; swe_nxt = 1'b0;
              end
            end
          end
        end
      end
      fs_nxt = fs_r + 3'd1;
    end else if (a < 5'(apucs_pkg::NREGS)) begin
      gated = !rf_r[apucs_pkg::R_NR52][7] && a != apucs_pkg::R_NR52 &&
              (cgb_r || (a != apucs_pkg::R_NR11 && a != apucs_pkg::R_NR21 &&
                         a != apucs_pkg::R_NR31 && a != apucs_pkg::R_NR41));
      if (!gated) begin
        rf_nxt[a] = v;
        unique case (a)
          apucs_pkg::R_NR10: begin
            if (neg_r && cnt[3] && !v[3]) begin
              vol_nxt[0] = '0; st_nxt[0] = 1'b0; neg_nxt = 1'b0;
            end
          end
          apucs_pkg::R_NR11: len_nxt[0] = 9'd64 - {3'd0, v[5:0]};
          apucs_pkg::R_NR21: len_nxt[1] = 9'd64 - {3'd0, v[5:0]};
          apucs_pkg::R_NR41: len_nxt[3] = 9'd64 - {3'd0, v[5:0]};
          apucs_pkg::R_NR31: len_nxt[2] = 9'd256 - {1'b0, v};
          apucs_pkg::R_NR12: if (v[7:3] == 5'd0) begin st_nxt[0] = 1'b0; vol_nxt[0] = '0; end
          apucs_pkg::R_NR22: if (v[7:3] == 5'd0) begin st_nxt[1] = 1'b0; vol_nxt[1] = '0; end
          apucs_pkg::R_NR42: if (v[7:3] == 5'd0) begin st_nxt[3] = 1'b0; vol_nxt[3] = '0; end
          apucs_pkg::R_NR14, apucs_pkg::R_NR24, apucs_pkg::R_NR44: begin
            if (v[7]) begin
              for (int ch = 0; ch < 4; ch++) begin
                if (ctl_idx(ch) == a) begin
                  envr = rf_r[env_idx(ch)];
                  vol_nxt[ch] = envr[7:4];
                  etm_nxt[ch] = envr[2:0];
                  len_nxt[ch] = (len_r[ch] == 9'd0) ? 9'd64 : len_r[ch];
                  st_nxt[ch] = 1'b1;
                  if (ch == 0) begin
                    swe_nxt = (cnt[2:0] != 3'd0) || (cnt[6:4] != 3'd0);
                    swt_nxt = (sp == 3'd0) ? 4'd8 : {1'b0, sp};
                    sws_nxt = {v[2:0], rf_r[apucs_pkg::R_NR13]};
                    neg_nxt = cnt[3];
                    if (cnt[2:0] != 3'd0) begin
                      d = sws_nxt >> cnt[2:0];
                      fr = cnt[3] ? ({1'b0, sws_nxt} - {1'b0, d})
                                  : ({1'b0, sws_nxt} + {1'b0, d});
                      if (fr > 12'd2047) begin
                        len_nxt[0] = '0; st_nxt[0] = 1'b0; swe_nxt = 1'b0;
                      end
                    end else begin
                      neg_nxt = 1'b0;
                    end
                  end
                  killed = 1'b0;
                  if (!rf_r[ctl_idx(ch)][6] && v[6] && fs_r[0] && len_nxt[ch] != 9'd0) begin
                    len_nxt[ch] = len_nxt[ch] - 9'd1;
                    killed = (len_nxt[ch] == 9'd0);
                  end
                  if (killed || envr[7:3] == 5'd0 || !st_nxt[ch]) begin
                    st_nxt[ch] = 1'b0; vol_nxt[ch] = '0;
                  end
                end
              end
            end
          end
          apucs_pkg::R_NR30: if (!v[7]) st_nxt[2] = 1'b0;
          apucs_pkg::R_NR34: begin
            if (v[7]) begin
              if (len_r[2] == 9'd0) len_nxt[2] = 9'd256;
              if (rf_r[apucs_pkg::R_NR30][7]) st_nxt[2] = 1'b1;
            end
          end
          apucs_pkg::R_NR52: begin
            st_nxt = {v[7:4], st_r[3:0]};
            if (!v[7]) begin
              for (int i = 0; i < apucs_pkg::NREGS - 1; i++)
                rf_nxt[i] = apucs_pkg::clear_val(5'(i));
              if (cgb_r) begin
                for (int ch = 0; ch < 4; ch++) len_nxt[ch] = '0;
                st_nxt = '0;
              end
            end else if (!rf_r[apucs_pkg::R_NR52][7]) begin
              fs_nxt = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  res_t res_nxt;
  always_comb begin
    res_nxt.on = st_nxt[3:0];
    res_nxt.v0 = vol_nxt[0];
    res_nxt.v1 = vol_nxt[1];
    res_nxt.v3 = vol_nxt[3];
    res_nxt.f  = sws_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cgb_r <= 1'b0;
      for (int i = 0; i < apucs_pkg::NREGS; i++) rf_r[i] <= '0;
      for (int ch = 0; ch < 4; ch++) begin
        len_r[ch] <= '0; vol_r[ch] <= '0; etm_r[ch] <= '0;
      end
      st_r <= '0; fs_r <= '0; swe_r <= 1'b0; swt_r <= '0; sws_r <= '0; neg_r <= 1'b0;
      out_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (cfg_we) cgb_r <= cfg_wdata;
      if (take) begin
        rf_r <= rf_nxt; len_r <= len_nxt; vol_r <= vol_nxt; etm_r <= etm_nxt;
        st_r <= st_nxt; fs_r <= fs_nxt; swe_r <= swe_nxt; swt_r <= swt_nxt;
        sws_r <= sws_nxt; neg_r <= neg_nxt;
      end
      if (!out_vld_r || out_ready) begin
        if (skid_vld_r) begin
          out_r <= skid_r;
          out_vld_r <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= take;
          if (take) out_r <= res_nxt;
        end
      end else if (take) begin
        skid_r <= res_nxt;
        skid_vld_r <= 1'b1;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_channel_on = out_r.on;
  assign out_square1_volume = out_r.v0;
  assign out_square2_volume = out_r.v1;
  assign out_noise_volume = out_r.v3;
  assign out_swept_frequency = out_r.f;
endmodule
`default_nettype wire

### hw/rtl/apucs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module apucs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_channel_on
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel_on))
    else $error("result changed while stalled");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("transfer gave no result");
  a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |=> in_ready || !out_ready || $past(!out_ready))
    else $error("input stuck");
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule
bind apu_channel_control_sequencer apucs_checker u_apucs_checker (.*);
`default_nettype wire
